/* rtl/ssoc_pkg.sv */
// Shared types, constants and arithmetic helpers for the state-space
// observer controller. Used by ssoc_lane, ssoc_merge and the top level.
// No dependencies.
package ssoc_pkg;

    // Active problem size
    localparam int STATE_CNT  = 2;
    localparam int OUTPUT_CNT = 2;

    // Maximum sizes set by the coefficient layout
    localparam int MAXS   = 4;
    localparam int MAXO   = 2;
    localparam int SIDX_W = 2;
    localparam int OIDX_W = 1;

    // Word widths
    localparam int DW    = 32;
    localparam int PW    = 48;
    localparam int ACC_W = 51;

    // Coefficient table layout
    localparam logic [5:0] OFS_A    = 6'd0;
    localparam logic [5:0] OFS_B    = 6'd16;
    localparam logic [5:0] OFS_C    = 6'd24;
    localparam logic [5:0] OFS_L    = 6'd32;
    localparam logic [5:0] OFS_K    = 6'd40;
    localparam logic [5:0] OFS_UMAX = 6'd48;
    localparam logic [5:0] OFS_UMIN = 6'd50;
    localparam logic [5:0] OFS_END  = 6'd52;

    // Input command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Lane step codes
    typedef enum logic [2:0] {
        STEP_NONE,
        STEP_ERR,
        STEP_MUL,
        STEP_ACC,
        STEP_BSAVE,
        STEP_YSAVE,
        STEP_ALC,
        STEP_XACC
    } lane_step_t;

    // Multiplier operand selection
    typedef enum logic [2:0] {
        OP_KE,
        OP_BU,
        OP_LY,
        OP_LC,
        OP_AX
    } lane_op_t;

    typedef struct packed {
        lane_step_t          step;
        lane_op_t            op;
        logic [OIDX_W-1:0]   k;
        logic [SIDX_W-1:0]   j;
        logic                first;
    } lane_ctrl_t;

    typedef struct packed {
        logic                en;
        logic [5:0]          idx;
        logic signed [DW-1:0] val;
    } coef_wr_t;

    // Q16.16 product, floor of the exact product over 2^16
    function automatic logic signed [PW-1:0] qmul(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        logic signed [2*DW-1:0] p;
        p = a * b;
        return p[2*DW-1:16];
    endfunction

    function automatic logic signed [ACC_W-1:0] sext32(input logic signed [DW-1:0] v);
        return {{(ACC_W-DW){v[DW-1]}}, v};
    endfunction

    function automatic logic signed [ACC_W-1:0] sextp(input logic signed [PW-1:0] v);
        return {{(ACC_W-PW){v[PW-1]}}, v};
    endfunction

    // Saturate a wide sum to the signed 32-bit range
    function automatic logic signed [DW-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [DW-1:0] r;
        if ((&v[ACC_W-1:DW-1]) || (~|v[ACC_W-1:DW-1])) begin
            r = v[DW-1:0];
        end else if (v[ACC_W-1]) begin
            r = {1'b1, {(DW-1){1'b0}}};
        end else begin
            r = {1'b0, {(DW-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

/* rtl/ssoc_lane.sv */
// One state lane: its rows of A, B, L, its column of K, a copy of C,
// one multiplier and two accumulators. Depends on ssoc_pkg.
module ssoc_lane (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [ssoc_pkg::SIDX_W-1:0]          lane_id,
    input  ssoc_pkg::coef_wr_t                   wr,
    input  ssoc_pkg::lane_ctrl_t                 ctrl,
    input  logic signed [ssoc_pkg::DW-1:0]       ref_in,
    input  logic signed [ssoc_pkg::DW-1:0]       est_in,
    input  logic signed [ssoc_pkg::DW-1:0]       shared_in,
    output logic signed [ssoc_pkg::PW-1:0]       prod_out,
    output logic signed [ssoc_pkg::DW-1:0]       next_est
);

    logic signed [ssoc_pkg::DW-1:0]    a_row_reg [ssoc_pkg::MAXS];
    logic signed [ssoc_pkg::DW-1:0]    b_row_reg [ssoc_pkg::MAXO];
    logic signed [ssoc_pkg::DW-1:0]    l_row_reg [ssoc_pkg::MAXO];
    logic signed [ssoc_pkg::DW-1:0]    k_col_reg [ssoc_pkg::MAXO];
    logic signed [ssoc_pkg::DW-1:0]    c_mat_reg [ssoc_pkg::MAXS*ssoc_pkg::MAXO];
    logic signed [ssoc_pkg::DW-1:0]    e_reg, alc_reg, bu_reg, ly_reg;
    logic signed [ssoc_pkg::PW-1:0]    prod_reg;
    logic signed [ssoc_pkg::ACC_W-1:0] acc_reg, ax_reg;
    logic [5:0]                        off;
    logic signed [ssoc_pkg::DW-1:0]    op_a, op_b, lc, t0, t1;

    // Select multiplier operands
    always_comb begin
        op_a = '0;
        op_b = shared_in;
        case (ctrl.op)
            ssoc_pkg::OP_KE: begin op_a = k_col_reg[ctrl.k]; op_b = e_reg; end
            ssoc_pkg::OP_BU: op_a = b_row_reg[ctrl.k];
            ssoc_pkg::OP_LY: op_a = l_row_reg[ctrl.k];
            ssoc_pkg::OP_LC: begin
                op_a = l_row_reg[ctrl.k];
                op_b = c_mat_reg[{ctrl.k, ctrl.j}];
            end
            ssoc_pkg::OP_AX: op_a = alc_reg;
            default: op_a = '0;
        endcase
    end

    // Table write: decode the slot against this lane
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < ssoc_pkg::MAXS; n++) a_row_reg[n] <= '0;
            for (int n = 0; n < ssoc_pkg::MAXO; n++) begin
                b_row_reg[n] <= '0;
                l_row_reg[n] <= '0;
                k_col_reg[n] <= '0;
            end
            for (int n = 0; n < ssoc_pkg::MAXS*ssoc_pkg::MAXO; n++) c_mat_reg[n] <= '0;
        end else if (wr.en) begin
            if (wr.idx < ssoc_pkg::OFS_B) begin
                if (wr.idx[3:2] == lane_id) a_row_reg[wr.idx[1:0]] <= wr.val;
            end else if (wr.idx < ssoc_pkg::OFS_C) begin
                if (off[2:1] == lane_id) b_row_reg[off[0]] <= wr.val;
            end else if (wr.idx < ssoc_pkg::OFS_L) begin
                c_mat_reg[off[2:0]] <= wr.val;
            end else if (wr.idx < ssoc_pkg::OFS_K) begin
                if (off[2:1] == lane_id) l_row_reg[off[0]] <= wr.val;
            end else if (wr.idx < ssoc_pkg::OFS_UMAX) begin
                if (off[1:0] == lane_id) k_col_reg[off[2]] <= wr.val;
            end
        end
    end

    // Offset of the slot within its matrix
    always_comb begin
        if (wr.idx < ssoc_pkg::OFS_C)      off = wr.idx - ssoc_pkg::OFS_B;
        else if (wr.idx < ssoc_pkg::OFS_L) off = wr.idx - ssoc_pkg::OFS_C;
        else if (wr.idx < ssoc_pkg::OFS_K) off = wr.idx - ssoc_pkg::OFS_L;
        else                               off = wr.idx - ssoc_pkg::OFS_K;
    end

    // Datapath steps
    always_ff @(posedge aclk) begin
        case (ctrl.step)
            ssoc_pkg::STEP_ERR:
                e_reg <= ssoc_pkg::sat32(ssoc_pkg::sext32(ref_in) - ssoc_pkg::sext32(est_in));
            ssoc_pkg::STEP_MUL:
                prod_reg <= ssoc_pkg::qmul(op_a, op_b);
            ssoc_pkg::STEP_ACC:
                acc_reg <= (ctrl.first ? '0 : acc_reg) + ssoc_pkg::sextp(prod_reg);
            ssoc_pkg::STEP_BSAVE:
                bu_reg <= ssoc_pkg::sat32(acc_reg);
            ssoc_pkg::STEP_YSAVE:
                ly_reg <= ssoc_pkg::sat32(acc_reg);
            ssoc_pkg::STEP_ALC:
                alc_reg <= ssoc_pkg::sat32(ssoc_pkg::sext32(a_row_reg[ctrl.j])
                                           - ssoc_pkg::sext32(lc));
            ssoc_pkg::STEP_XACC:
                ax_reg <= (ctrl.first ? '0 : ax_reg) + ssoc_pkg::sextp(prod_reg);
            default: ;
        endcase
    end

    // Combine the terms of the new estimate
    always_comb begin
        lc       = ssoc_pkg::sat32(acc_reg);
        t0       = ssoc_pkg::sat32(ax_reg);
        t1       = ssoc_pkg::sat32(ssoc_pkg::sext32(t0) + ssoc_pkg::sext32(ly_reg));
        next_est = ssoc_pkg::sat32(ssoc_pkg::sext32(t1) + ssoc_pkg::sext32(bu_reg));
    end

    assign prod_out = prod_reg;

endmodule

/* rtl/ssoc_merge.sv */
// Merge stage: sums the lanes' K(r - xhat) products, saturates and clamps
// each drive to its limits. Holds the limit registers. Depends on ssoc_pkg.
module ssoc_merge (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  ssoc_pkg::coef_wr_t                   wr,
    input  logic                                 en,
    input  logic [ssoc_pkg::OIDX_W-1:0]          k,
    input  logic signed [ssoc_pkg::PW-1:0]       prod [ssoc_pkg::MAXS],
    output logic signed [ssoc_pkg::DW-1:0]       drive [ssoc_pkg::MAXO],
    output logic [ssoc_pkg::MAXO-1:0]            sat
);

    logic signed [ssoc_pkg::DW-1:0]    hi_reg [ssoc_pkg::MAXO];
    logic signed [ssoc_pkg::DW-1:0]    lo_reg [ssoc_pkg::MAXO];
    logic signed [ssoc_pkg::DW-1:0]    u_reg  [ssoc_pkg::MAXO];
    logic [ssoc_pkg::MAXO-1:0]         sat_reg;
    logic signed [ssoc_pkg::ACC_W-1:0] sum;
    logic signed [ssoc_pkg::DW-1:0]    u_raw;

    always_comb begin
        sum = '0;
        for (int n = 0; n < ssoc_pkg::MAXS; n++) sum = sum + ssoc_pkg::sextp(prod[n]);
        u_raw = ssoc_pkg::sat32(sum);
    end

    // Write limits, clamp and hold the drive
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < ssoc_pkg::MAXO; n++) begin
                hi_reg[n] <= '0;
                lo_reg[n] <= '0;
                u_reg[n]  <= '0;
            end
            sat_reg <= '0;
        end else begin
            if (wr.en && wr.idx[5:1] == ssoc_pkg::OFS_UMAX[5:1]) hi_reg[wr.idx[0]] <= wr.val;
            if (wr.en && wr.idx[5:1] == ssoc_pkg::OFS_UMIN[5:1]) lo_reg[wr.idx[0]] <= wr.val;
            if (en) begin
                if (u_raw > hi_reg[k]) begin
                    u_reg[k]   <= hi_reg[k];
                    sat_reg[k] <= 1'b1;
                end else if (u_raw < lo_reg[k]) begin
                    u_reg[k]   <= lo_reg[k];
                    sat_reg[k] <= 1'b1;
                end else begin
                    u_reg[k]   <= u_raw;
                    sat_reg[k] <= 1'b0;
                end
            end
        end
    end

    assign drive = u_reg;
    assign sat   = sat_reg;

endmodule

/* rtl/state_space_observer_controller.sv */
// Top level of the state-space observer controller: handshake, sequencer,
// estimate registers, state lanes and merge stage. Depends on ssoc_pkg,
// ssoc_lane and ssoc_merge.
//
// Usage: the slave channel (s_tvalid/s_tready/s_tdata/s_tuser) takes one
// word per item. s_tuser = 0 loads one Q16.16 coefficient into the table
// slot s_tdata[5:0]; slots above 51 are dropped. A load
// returns nothing. s_tuser = 1 runs one control step on the reference
// and measurement in s_tdata, returns the clamped drives and clamp flags
// as one word on the master channel and advances the estimate.
// A step occupies the block through its sequencer states, with one shared
// multiplier per lane that is stepped through every dot product; the
// result is loaded into the output register as the step leaves its last
// state. Loads are taken one a cycle while the block is idle.
// The result word waits in the output register while the receiver stalls;
// the block keeps accepting loads and runs the next step, which holds in
// its last cycle until the output register is free. Reset clears the
// estimate, the coefficient table and the output valid.
module state_space_observer_controller (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // coef_index[5:0], coef_value[37:6], ref_0[69:38], ref_1[101:70],
    // ref_2[133:102], ref_3[165:134], meas_0[197:166], meas_1[229:198]
    input  logic [231:0] s_tdata,
    // command[0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // drive_0[31:0], drive_1[63:32], sat_0[64], sat_1[65]
    output logic [71:0]  m_tdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_ERR, S_UMUL, S_UMRG, S_BMUL, S_BACC, S_BSAVE, S_YMUL,
        S_YACC, S_YSAVE, S_CMUL, S_CACC, S_ALC, S_XMUL, S_XACC, S_FIN
    } state_t;

    localparam logic [ssoc_pkg::OIDX_W-1:0] K_LAST = ssoc_pkg::OIDX_W'(ssoc_pkg::OUTPUT_CNT-1);
    localparam logic [ssoc_pkg::SIDX_W-1:0] J_LAST = ssoc_pkg::SIDX_W'(ssoc_pkg::STATE_CNT-1);

    state_t                          state_reg;
    logic [ssoc_pkg::OIDX_W-1:0]     k_reg;
    logic [ssoc_pkg::SIDX_W-1:0]     j_reg;
    logic signed [ssoc_pkg::DW-1:0]  est_reg [ssoc_pkg::MAXS];
    logic signed [ssoc_pkg::DW-1:0]  ref_reg [ssoc_pkg::MAXS];
    logic signed [ssoc_pkg::DW-1:0]  meas_reg [ssoc_pkg::MAXO];
    logic                            m_tvalid_reg;
    logic [71:0]                     m_tdata_reg;

    logic                            accept, out_free;
    ssoc_pkg::coef_wr_t              wr;
    ssoc_pkg::lane_ctrl_t            ctrl;
    logic signed [ssoc_pkg::DW-1:0]  shared;
    logic signed [ssoc_pkg::PW-1:0]  prod [ssoc_pkg::MAXS];
    logic signed [ssoc_pkg::DW-1:0]  nx [ssoc_pkg::MAXS];
    logic signed [ssoc_pkg::DW-1:0]  drive [ssoc_pkg::MAXO];
    logic [ssoc_pkg::MAXO-1:0]       sat;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Coefficient write from a load word
    always_comb begin
        wr.en  = accept && (s_tuser[0] == ssoc_pkg::CMD_LOAD) && (s_tdata[5:0] < ssoc_pkg::OFS_END);
        wr.idx = s_tdata[5:0];
        wr.val = s_tdata[37:6];
    end

    // Lane control from the sequencer state
    always_comb begin
        ctrl.step  = ssoc_pkg::STEP_NONE;
        ctrl.op    = ssoc_pkg::OP_KE;
        ctrl.k     = k_reg;
        ctrl.j     = j_reg;
        ctrl.first = (k_reg == '0);
        shared     = '0;
        case (state_reg)
            S_ERR:   ctrl.step = ssoc_pkg::STEP_ERR;
            S_UMUL:  ctrl.step = ssoc_pkg::STEP_MUL;
            S_BMUL:  begin
                ctrl.step = ssoc_pkg::STEP_MUL;
                ctrl.op   = ssoc_pkg::OP_BU;
                shared    = drive[k_reg];
            end
            S_YMUL:  begin
                ctrl.step = ssoc_pkg::STEP_MUL;
                ctrl.op   = ssoc_pkg::OP_LY;
                shared    = meas_reg[k_reg];
            end
            S_CMUL:  begin
                ctrl.step = ssoc_pkg::STEP_MUL;
                ctrl.op   = ssoc_pkg::OP_LC;
            end
            S_XMUL:  begin
                ctrl.step = ssoc_pkg::STEP_MUL;
                ctrl.op   = ssoc_pkg::OP_AX;
                shared    = est_reg[j_reg];
            end
            S_BACC, S_YACC, S_CACC: ctrl.step = ssoc_pkg::STEP_ACC;
            S_BSAVE: ctrl.step = ssoc_pkg::STEP_BSAVE;
            S_YSAVE: ctrl.step = ssoc_pkg::STEP_YSAVE;
            S_ALC:   ctrl.step = ssoc_pkg::STEP_ALC;
            S_XACC:  begin
                ctrl.step  = ssoc_pkg::STEP_XACC;
                ctrl.first = (j_reg == '0);
            end
            default: ctrl.step = ssoc_pkg::STEP_NONE;
        endcase
    end

    // State lanes
    for (genvar g = 0; g < ssoc_pkg::MAXS; g++) begin : g_lane
        if (g < ssoc_pkg::STATE_CNT) begin : g_on
            ssoc_lane u_lane (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .lane_id   (ssoc_pkg::SIDX_W'(g)),
                .wr        (wr),
                .ctrl      (ctrl),
                .ref_in    (ref_reg[g]),
                .est_in    (est_reg[g]),
                .shared_in (shared),
                .prod_out  (prod[g]),
                .next_est  (nx[g])
            );
        end else begin : g_off
            assign prod[g] = '0;
            assign nx[g]   = '0;
        end
    end

    ssoc_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .en      (state_reg == S_UMRG),
        .k       (k_reg),
        .prod    (prod),
        .drive   (drive),
        .sat     (sat)
    );

    // Sequencer, estimate and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            k_reg        <= '0;
            j_reg        <= '0;
            m_tvalid_reg <= 1'b0;
            for (int n = 0; n < ssoc_pkg::MAXS; n++) est_reg[n] <= '0;
        end else begin
            // drop the taken word; the last step state refills it instead
            if (m_tvalid_reg && m_tready && state_reg != S_FIN) m_tvalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    k_reg <= '0;
                    j_reg <= '0;
                    if (accept && s_tuser[0] == ssoc_pkg::CMD_STEP) begin
                        for (int n = 0; n < ssoc_pkg::MAXS; n++)
                            ref_reg[n] <= s_tdata[38 + 32*n +: 32];
                        for (int n = 0; n < ssoc_pkg::MAXO; n++)
                            meas_reg[n] <= s_tdata[166 + 32*n +: 32];
                        state_reg <= S_ERR;
                    end
                end
                S_ERR:  state_reg <= S_UMUL;
                S_UMUL: state_reg <= S_UMRG;
                S_UMRG: begin
                    k_reg     <= (k_reg == K_LAST) ? '0 : k_reg + 1'b1;
                    state_reg <= (k_reg == K_LAST) ? S_BMUL : S_UMUL;
                end
                S_BMUL: state_reg <= S_BACC;
                S_BACC: begin
                    k_reg     <= (k_reg == K_LAST) ? '0 : k_reg + 1'b1;
                    state_reg <= (k_reg == K_LAST) ? S_BSAVE : S_BMUL;
                end
                S_BSAVE: state_reg <= S_YMUL;
                S_YMUL:  state_reg <= S_YACC;
                S_YACC: begin
                    k_reg     <= (k_reg == K_LAST) ? '0 : k_reg + 1'b1;
                    state_reg <= (k_reg == K_LAST) ? S_YSAVE : S_YMUL;
                end
                S_YSAVE: state_reg <= S_CMUL;
                S_CMUL:  state_reg <= S_CACC;
                S_CACC: begin
                    k_reg     <= (k_reg == K_LAST) ? '0 : k_reg + 1'b1;
                    state_reg <= (k_reg == K_LAST) ? S_ALC : S_CMUL;
                end
                S_ALC:  state_reg <= S_XMUL;
                S_XMUL: state_reg <= S_XACC;
                S_XACC: begin
                    j_reg     <= (j_reg == J_LAST) ? j_reg : j_reg + 1'b1;
                    state_reg <= (j_reg == J_LAST) ? S_FIN : S_CMUL;
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (out_free) begin
                        for (int n = 0; n < ssoc_pkg::STATE_CNT; n++) est_reg[n] <= nx[n];
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {6'b0, sat[1], sat[0], drive[1], drive[0]};
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
